// ----- design/sha256_pkg.sv -----
`timescale 1ns / 1ps
package sha256_pkg;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       has_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef logic [31:0] word_type;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam int unsigned LEN_POS = 56;

   function automatic word_type init_h(input logic [2:0] idx);
      word_type r;
      r = 32'h0;
      case (idx)
         3'd0: r = 32'h6a09e667;
         3'd1: r = 32'hbb67ae85;
         3'd2: r = 32'h3c6ef372;
         3'd3: r = 32'ha54ff53a;
         3'd4: r = 32'h510e527f;
         3'd5: r = 32'h9b05688c;
         3'd6: r = 32'h1f83d9ab;
         default: r = 32'h5be0cd19;
      endcase
      return r;
   endfunction

   function automatic word_type round_k(input logic [5:0] idx);
      word_type r;
      r = 32'h0;
      case (idx)
         6'd0: r = 32'h428a2f98; 6'd1: r = 32'h71374491; 6'd2: r = 32'hb5c0fbcf;
         6'd3: r = 32'he9b5dba5; 6'd4: r = 32'h3956c25b; 6'd5: r = 32'h59f111f1;
         6'd6: r = 32'h923f82a4; 6'd7: r = 32'hab1c5ed5; 6'd8: r = 32'hd807aa98;
         6'd9: r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
         6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
         6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
         6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
         6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
         6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
         6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
         6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
         6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
         6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
         6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
         6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
         6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
         6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
         6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
         6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
         6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
         6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
         default: r = 32'hc67178f2;
      endcase
      return r;
   endfunction

endpackage

// ----- design/sha256_hash_engine_core.sv -----
`timescale 1ns / 1ps
// Channel  | Ports                         | Beat accepted when
// request  | req_push, req_full, req_data  | req_push && !req_full
// response | rsp_pop, rsp_empty, rsp_data  | rsp_pop && !rsp_empty
// A byte beat is stored in the block buffer; a full block adds the round loop and a fold step.
// A last beat pads one byte per cycle to the block end, compresses once or twice,
// then presents eight digest beats, one per cycle while rsp_pop stays high.
// The four-entry request queue keeps taking beats while the round loop runs.
// Reset is synchronous and returns the chaining words to their initial values.
module sha256_hash_engine_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  sha256_pkg::req_type req_data,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output sha256_pkg::rsp_type rsp_data
);

   logic                q_empty, q_take;
   sha256_pkg::req_type q_data;

   sha256_fifo #(.DEPTH_LOG2(2)) u_fifo (
      .clock(clock), .reset(reset),
      .push(req_push), .push_data(req_data), .full(req_full),
      .pop(q_take), .empty(q_empty), .pop_data(q_data)
   );

   sha256_back u_back (
      .clock(clock), .reset(reset),
      .item_valid(!q_empty), .item(q_data), .item_take(q_take),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

   a_take_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_take |-> !q_empty) else $error("queue taken while empty");

   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.last_word == (rsp_data.word_index == 3'd7)))
      else $error("last word flag mismatch");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty) else $error("result dropped");

endmodule

// ----- design/sha256_fifo.sv -----
`timescale 1ns / 1ps
module sha256_fifo #(
   parameter int unsigned DEPTH_LOG2 = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sha256_pkg::req_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output sha256_pkg::req_type pop_data
);

   localparam int unsigned DEPTH = 1 << DEPTH_LOG2;

   sha256_pkg::req_type          mem_ff [DEPTH];
   logic [DEPTH_LOG2-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [DEPTH_LOG2:0]          count_ff;

   assign full     = (count_ff == DEPTH_LOG2'(0) + (DEPTH_LOG2+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push && !full) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop && !empty) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + (DEPTH_LOG2+1)'(push && !full)
                     - (DEPTH_LOG2+1)'(pop && !empty);
      end
   end

endmodule

// ----- design/sha256_back.sv -----
`timescale 1ns / 1ps
module sha256_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  sha256_pkg::req_type item,
   output logic                item_take,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output sha256_pkg::rsp_type rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_PAD, ST_ROUND, ST_FOLD, ST_OUT
   } state_type;

   state_type                state_ff;
   logic [7:0]               buf_ff [64];
   logic [5:0]               pos_ff;
   logic [63:0]              bits_ff;
   sha256_pkg::word_type     h_ff [8];
   sha256_pkg::word_type     v_ff [8];
   sha256_pkg::word_type     w_ff [16];
   logic [5:0]               rnd_ff;
   logic                     fin_ff;
   logic                     last_blk_ff;
   logic                     mark_ff;
   logic [2:0]               oidx_ff;
   logic                     ovalid_ff;
   sha256_pkg::rsp_type      out_ff;

   sha256_pkg::word_type a, e, t1, t2, s0, s1, wn, wcur, tail_word;
   logic [5:0] pad_pos;
   logic [7:0] pad_byte;

   function automatic sha256_pkg::word_type rotr(input sha256_pkg::word_type x,
                                                  input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   always_comb begin
      a    = v_ff[0];
      e    = v_ff[4];
      wcur = w_ff[0];
      t1 = v_ff[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
           + ((e & v_ff[5]) ^ (~e & v_ff[6])) + sha256_pkg::round_k(rnd_ff) + wcur;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
           + ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      s0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wn = s1 + w_ff[9] + s0 + w_ff[0];
   end

   // The last word of the block includes whatever the incoming beat writes there.
   always_comb begin
      tail_word = {buf_ff[60], buf_ff[61], buf_ff[62], buf_ff[63]};
      if (item.has_byte && pos_ff == 6'd63) begin
         tail_word[7:0] = item.byte_value;
      end else if (item.last_byte && item.has_byte && pos_ff == 6'd62) begin
         tail_word[15:0] = {item.byte_value, sha256_pkg::PAD_BYTE};
      end else if (item.last_byte && pos_ff == 6'd63) begin
         tail_word[7:0] = sha256_pkg::PAD_BYTE;
      end
   end

   // Padding fills one byte a cycle from pos_ff to the end of the block.
   always_comb begin
      pad_pos  = pos_ff;
      pad_byte = 8'h00;
      if (mark_ff) begin
         pad_byte = sha256_pkg::PAD_BYTE;
      end else if (pos_ff >= 6'(sha256_pkg::LEN_POS) && last_blk_ff) begin
         pad_byte = bits_ff[8*(7 - 32'(pos_ff[2:0])) +: 8];
      end
   end

   assign item_take = (state_ff == ST_IDLE) && item_valid;
   assign rsp_empty = !ovalid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pos_ff    <= '0;
         bits_ff   <= '0;
         ovalid_ff <= 1'b0;
         fin_ff    <= 1'b0;
         last_blk_ff <= 1'b0;
         mark_ff   <= 1'b0;
         rnd_ff    <= '0;
         oidx_ff   <= '0;
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= sha256_pkg::init_h(3'(i));
         end
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (item_valid) begin
                  fin_ff <= item.last_byte;
                  rnd_ff <= '0;
                  for (int i = 0; i < 8; i++) begin
                     v_ff[i] <= h_ff[i];
                  end
                  for (int i = 0; i < 15; i++) begin
                     w_ff[i] <= {buf_ff[4*i], buf_ff[4*i+1], buf_ff[4*i+2],
                                 buf_ff[4*i+3]};
                  end
                  w_ff[15] <= tail_word;
                  if (item.has_byte) begin
                     bits_ff <= bits_ff + 64'd8;
                  end
                  if (item.has_byte && pos_ff == 6'd63) begin
                     // The byte completes the block; a last beat owes the marker.
                     buf_ff[pos_ff] <= item.byte_value;
                     pos_ff <= '0;
                     mark_ff <= item.last_byte;
                     last_blk_ff <= 1'b0;
                     state_ff <= ST_ROUND;
                  end else if (item.last_byte && item.has_byte) begin
                     buf_ff[pos_ff] <= item.byte_value;
                     buf_ff[pos_ff + 6'd1] <= sha256_pkg::PAD_BYTE;
                     pos_ff <= pos_ff + 6'd2;
                     last_blk_ff <= (pos_ff + 6'd2 <= 6'(sha256_pkg::LEN_POS))
                                    && (pos_ff != 6'd62);
                     state_ff <= (pos_ff == 6'd62) ? ST_ROUND : ST_PAD;
                  end else if (item.last_byte) begin
                     buf_ff[pos_ff] <= sha256_pkg::PAD_BYTE;
                     pos_ff <= pos_ff + 6'd1;
                     last_blk_ff <= (pos_ff < 6'(sha256_pkg::LEN_POS));
                     state_ff <= (pos_ff == 6'd63) ? ST_ROUND : ST_PAD;
                  end else if (item.has_byte) begin
                     buf_ff[pos_ff] <= item.byte_value;
                     pos_ff <= pos_ff + 6'd1;
                  end
               end
            end
            ST_PAD: begin
               buf_ff[pad_pos] <= pad_byte;
               pos_ff <= pos_ff + 6'd1;
               mark_ff <= 1'b0;
               if (pos_ff == 6'd63) begin
                  state_ff <= ST_ROUND;
                  rnd_ff <= '0;
                  for (int i = 0; i < 8; i++) begin
                     v_ff[i] <= h_ff[i];
                  end
                  for (int i = 0; i < 15; i++) begin
                     w_ff[i] <= {buf_ff[4*i], buf_ff[4*i+1], buf_ff[4*i+2],
                                 buf_ff[4*i+3]};
                  end
                  w_ff[15] <= {buf_ff[60], buf_ff[61], buf_ff[62], pad_byte};
               end else if (pos_ff == 6'd0 && !last_blk_ff) begin
                  last_blk_ff <= 1'b1;
               end
            end
            ST_ROUND: begin
               v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + t2;
               for (int i = 0; i < 15; i++) begin
                  w_ff[i] <= w_ff[i+1];
               end
               w_ff[15] <= wn;
               rnd_ff <= rnd_ff + 6'd1;
               if (rnd_ff == 6'd63) begin
                  state_ff <= ST_FOLD;
               end
            end
            ST_FOLD: begin
               for (int i = 0; i < 8; i++) begin
                  h_ff[i] <= h_ff[i] + v_ff[i];
               end
               if (!fin_ff) begin
                  state_ff <= ST_IDLE;
               end else if (!last_blk_ff) begin
                  // The marker left no room for the length field, or is still owed; one more block follows.
                  state_ff <= ST_PAD;
                  pos_ff <= '0;
               end else begin
                  state_ff <= ST_OUT;
                  oidx_ff <= '0;
               end
            end
            ST_OUT: begin
               if (!ovalid_ff || rsp_pop) begin
                  ovalid_ff <= 1'b1;
                  out_ff.digest_word <= h_ff[oidx_ff];
                  out_ff.word_index  <= oidx_ff;
                  out_ff.last_word   <= (oidx_ff == 3'd7);
                  oidx_ff <= oidx_ff + 3'd1;
                  if (oidx_ff == 3'd7) begin
                     state_ff <= ST_IDLE;
                     pos_ff <= '0;
                     bits_ff <= '0;
                     fin_ff <= 1'b0;
                     for (int i = 0; i < 8; i++) begin
                        h_ff[i] <= sha256_pkg::init_h(3'(i));
                     end
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         if (ovalid_ff && rsp_pop && !(state_ff == ST_OUT)) begin
            ovalid_ff <= 1'b0;
         end
      end
   end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

   localparam int CYCLE_LIMIT = 2000000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_push = 1'b0;
   logic                req_full;
   sha256_pkg::req_type req_data = '0;
   logic                rsp_empty;
   logic                rsp_pop = 1'b0;
   sha256_pkg::rsp_type rsp_data;

   sha256_hash_engine_core u_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   sha256_pkg::req_type pending_beats[$];
   sha256_pkg::rsp_type expected_words[$];
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   bit      failed = 1'b0;
   bit      beat_taken = 1'b0;
   longint  cycle_count = 0;

   // Predictor state.
   logic [31:0] hash_state[8];
   logic [7:0]  block_buf[64];
   logic [5:0]  fill_count;
   logic [63:0] bit_count;

   localparam logic [31:0] ROUND_CONST[64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam logic [31:0] START_HASH[8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic clear_hash();
      hash_state = START_HASH;
      fill_count = '0;
      bit_count = '0;
   endtask

   task automatic compress_block();
      logic [31:0] w[64];
      logic [31:0] v[8];
      logic [31:0] t1, t2, s0, s1;
      for (int i = 0; i < 16; i++) begin
         w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
      end
      for (int i = 16; i < 64; i++) begin
         s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = s1 + w[i-7] + s0 + w[i-16];
      end
      v = hash_state;
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + w[i];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += v[i];
   endtask

   task automatic hash_beat(input sha256_pkg::req_type beat);
      int p;
      sha256_pkg::rsp_type r;
      if (beat.has_byte) begin
         block_buf[fill_count] = beat.byte_value;
         bit_count += 64'd8;
         fill_count = fill_count + 6'd1;
         if (fill_count == 6'd0) compress_block();
      end
      if (beat.last_byte) begin
         p = fill_count;
         block_buf[p] = sha256_pkg::PAD_BYTE;
         p++;
         if (p > sha256_pkg::LEN_POS) begin
            while (p < 64) begin block_buf[p] = 8'h00; p++; end
            compress_block();
            p = 0;
         end
         while (p < sha256_pkg::LEN_POS) begin block_buf[p] = 8'h00; p++; end
         for (int i = 0; i < 8; i++) begin
            block_buf[sha256_pkg::LEN_POS + i] = bit_count[63 - 8*i -: 8];
         end
         compress_block();
         for (int i = 0; i < 8; i++) begin
            r.digest_word = hash_state[i];
            r.word_index = 3'(i);
            r.last_word = (i == 7);
            expected_words.push_back(r);
         end
         clear_hash();
      end
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         rsp_pop <= 1'b0;
      end else begin
         if (!req_push || beat_taken) begin
            if (beat_taken) void'(pending_beats.pop_front());
            if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_push <= 1'b1;
               req_data <= pending_beats[0];
            end else begin
               req_push <= 1'b0;
            end
         end
         rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // The driver pops its queue on the falling edge after acceptance, so the monitor
   // predicts from the beat on the port at the rising edge.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      beat_taken = !reset && req_push && !req_full;
      if (beat_taken) hash_beat(req_data);
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected beat %h", $time, rsp_data);
            failed = 1'b1;
         end else begin
            if (rsp_data !== expected_words[0]) begin
               $display("%0t: expected %h actual %h", $time, expected_words[0], rsp_data);
               failed = 1'b1;
            end
            void'(expected_words.pop_front());
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sha256_hash_engine_core test failed");
         $finish;
      end
   end

   task automatic add_beat(input logic [7:0] b, input logic hb, input logic lb);
      sha256_pkg::req_type t;
      t.byte_value = b;
      t.has_byte = hb;
      t.last_byte = lb;
      pending_beats.push_back(t);
   endtask

   task automatic add_message(input int len, input bit final_has_byte);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(9) == 0) add_beat(8'($urandom), 1'b0, 1'b0);
         add_beat(8'($urandom), 1'b1, 1'b0);
      end
      if (final_has_byte) add_beat(8'($urandom), 1'b1, 1'b1);
      else add_beat(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic wait_drained();
      while (pending_beats.size() > 0 || req_push || expected_words.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      int phase_idle[4] = '{0, 66, 0, 9};
      int phase_stall[4] = '{0, 0, 66, 9};
      int corner_len[4] = '{55, 62, 63, 63};
      bit corner_last[4] = '{1'b1, 1'b1, 1'b0, 1'b1};
      int len;
      clear_hash();
      for (int i = 0; i < 64; i++) block_buf[i] = 8'h00;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_beat(8'h00, 1'b0, 1'b1);
      add_beat(8'h00, 1'b0, 1'b0);
      add_beat(8'hff, 1'b1, 1'b1);
      add_beat(8'h00, 1'b1, 1'b1);
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = phase_idle[ph];
         recv_stall_pct = phase_stall[ph];
         add_message(corner_len[ph], corner_last[ph]);
         for (int m = 0; m < 4; m++) begin
            len = $urandom_range(8);
            add_message(len, 1'($urandom_range(1)));
         end
         wait_drained();
      end
      repeat (200) @(posedge clock);
      if (!failed && expected_words.size() == 0) begin
         $display("sha256_hash_engine_core test passed");
      end else begin
         $display("sha256_hash_engine_core test failed");
      end
      $finish;
   end
endmodule

// ----- files.f -----
design/sha256_pkg.sv
design/sha256_fifo.sv
design/sha256_back.sv
design/sha256_hash_engine_core.sv
verif/testbench.sv
